FILE: sv/mcst_pkg.sv
// -----------------------------------------------------------------------------
// MIDI control state tracker package
// Shared item types, operation and status codes, and sequencer types.
// -----------------------------------------------------------------------------
package mcst_pkg;

   localparam logic [2:0] OP_MIDI      = 3'd0;
   localparam logic [2:0] OP_READ      = 3'd1;
   localparam logic [2:0] OP_CLEAR     = 3'd2;
   localparam logic [2:0] OP_POP       = 3'd3;
   localparam logic [2:0] OP_TAKE_FLAG = 3'd4;

   localparam logic [7:0] ST_CONTROL = 8'd176;
   localparam logic [7:0] ST_PRESS   = 8'd144;
   localparam logic [7:0] ST_RELEASE = 8'd128;

   localparam logic [1:0] KIND_SLIDER   = 2'd0;
   localparam logic [1:0] KIND_HELD     = 2'd1;
   localparam logic [1:0] KIND_TOGGLE   = 2'd2;
   localparam logic [1:0] KIND_SELECTOR = 2'd3;

   localparam logic signed [7:0] NO_BUTTON = -8'sd1;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] midi_status;
      logic [6:0] channel_index;
      logic [6:0] midi_value;
      logic [1:0] store_kind;
   } req_type;

   typedef struct packed {
      logic [6:0]        value_out;
      logic              changed_valid;
      logic [1:0]        changed_kind;
      logic [6:0]        changed_index;
      logic signed [7:0] last_button;
      logic signed [7:0] previous_button;
      logic              button_changed;
   } rsp_type;

   typedef struct packed {
      logic [3:0] dirty;
      logic       selector;
      logic       toggle;
      logic       held;
      logic [6:0] slider;
   } row_type;

   typedef enum logic [2:0] {
      MODE_NONE,
      MODE_SLIDER,
      MODE_RELEASE,
      MODE_PRESS,
      MODE_CLEAR,
      MODE_READ,
      MODE_SCAN,
      MODE_POP
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic       self_hit;
      logic [1:0] kind;
      logic [6:0] level;
   } row_ctl_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_RD,
      S_WR,
      S_DONE
   } state_type;

endpackage

FILE: sv/mcst_row_unit.sv
// -----------------------------------------------------------------------------
// MIDI control state tracker row unit
// Updates one channel row (slider, held, toggle, selector, dirty bits).
// -----------------------------------------------------------------------------
module mcst_row_unit (
   input  mcst_pkg::row_type     cur_row,
   input  mcst_pkg::row_ctl_type ctl,
   output mcst_pkg::row_type     new_row
);
   import mcst_pkg::*;

   always_comb begin
      new_row = cur_row;
      unique case (ctl.mode)
         MODE_SLIDER: begin
            if (cur_row.slider != ctl.level) begin
               new_row.slider             = ctl.level;
               new_row.dirty[KIND_SLIDER] = 1'b1;
            end
         end
         MODE_RELEASE: begin
            if (cur_row.held) begin
               new_row.held             = 1'b0;
               new_row.dirty[KIND_HELD] = 1'b1;
            end
         end
         MODE_PRESS: begin
            if (ctl.self_hit) begin
               if (!cur_row.held) begin
                  new_row.held             = 1'b1;
                  new_row.dirty[KIND_HELD] = 1'b1;
               end
               new_row.toggle             = ~cur_row.toggle;
               new_row.dirty[KIND_TOGGLE] = 1'b1;
               if (!cur_row.selector) begin
                  new_row.selector             = 1'b1;
                  new_row.dirty[KIND_SELECTOR] = 1'b1;
               end
            end else if (cur_row.selector) begin
               new_row.selector             = 1'b0;
               new_row.dirty[KIND_SELECTOR] = 1'b1;
            end
         end
         MODE_CLEAR: begin
            unique case (ctl.kind)
               KIND_SLIDER: begin
                  if (cur_row.slider != 7'd0) new_row.dirty[KIND_SLIDER] = 1'b1;
                  new_row.slider = 7'd0;
               end
               KIND_HELD: begin
                  if (cur_row.held) new_row.dirty[KIND_HELD] = 1'b1;
                  new_row.held = 1'b0;
               end
               KIND_TOGGLE: begin
                  if (cur_row.toggle) new_row.dirty[KIND_TOGGLE] = 1'b1;
                  new_row.toggle = 1'b0;
               end
               KIND_SELECTOR: begin
                  if (cur_row.selector) new_row.dirty[KIND_SELECTOR] = 1'b1;
                  new_row.selector = 1'b0;
               end
               default: ;
            endcase
         end
         MODE_POP: begin
            new_row.dirty[ctl.kind] = 1'b0;
         end
         default: ;
      endcase
   end

endmodule

FILE: sv/midi_control_state_tracker.sv
// -----------------------------------------------------------------------------
// MIDI control state tracker
// Per-channel slider, held, toggle and selector state with dirty tracking.
// -----------------------------------------------------------------------------
// One item at a time runs through a sequencer around a single-port channel
// table of NUM_CHANNELS rows. Each row that an item touches is read and,
// unless the item only reads, updated through one row unit and written back.
// After reset a clearing pass zeroes every row before the first item is taken.
// A control or release message rewrites its row and an in-range read reads
// its row; a flag take, an unknown op, an ignored message or an out-of-range
// read goes straight to the result; a press or a clear walks every row; a pop
// walks every row, then rewrites the popped row when it found one. An item that
// finishes while the output register is still stalled waits until the stall
// ends. A finished result sits in an output register, so the next item can be
// taken while it waits.
// -----------------------------------------------------------------------------
module midi_control_state_tracker #(
   parameter int NUM_CHANNELS = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mcst_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mcst_pkg::rsp_type rsp_payload
);
   import mcst_pkg::*;

   localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [IW-1:0] LAST = IW'(NUM_CHANNELS - 1);

   state_type         state_ff, state_in;
   logic [IW-1:0]     addr_ff, addr_in;
   logic [IW-1:0]     tgt_ff, tgt_in;
   mode_type          mode_ff, mode_in;
   logic              sweep_ff, sweep_in;
   logic [2:0]        op_ff, op_in;
   logic [1:0]        kind_ff, kind_in;
   logic [6:0]        level_ff, level_in;
   logic [6:0]        value_ff, value_in;
   logic              cvalid_ff, cvalid_in;
   logic [1:0]        ckind_ff, ckind_in;
   logic [6:0]        cindex_ff, cindex_in;
   logic [3:0]        found_ff, found_in;
   logic [IW-1:0]     fidx_ff [4];
   logic [IW-1:0]     fidx_in [4];
   logic signed [7:0] last_ff, last_in;
   logic signed [7:0] prev_ff, prev_in;
   logic              flag_ff, flag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   row_type           mem_ff [NUM_CHANNELS];
   row_type           rd_row_ff;
   row_type           unit_row;
   row_type           mem_wd;
   logic              mem_we;
   row_ctl_type       unit_ctl;

   logic [IW+6:0]     idx_ext;
   logic [IW-1:0]     idx_addr;
   logic              idx_ok;
   logic [6:0]        req_idx;
   logic              pick_hit;
   logic [1:0]        pick_kind;
   logic [IW+6:0]     pick_ext;

   assign req_idx  = req_payload.channel_index;
   assign idx_ext  = {{IW{1'b0}}, req_idx};
   assign idx_addr = idx_ext[IW-1:0];
   assign idx_ok   = 32'(req_idx) < NUM_CHANNELS;

   assign unit_ctl.mode     = mode_ff;
   assign unit_ctl.self_hit = (addr_ff == tgt_ff);
   assign unit_ctl.kind     = kind_ff;
   assign unit_ctl.level    = level_ff;

   mcst_row_unit u_row (
      .cur_row (rd_row_ff),
      .ctl     (unit_ctl),
      .new_row (unit_row)
   );

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      tgt_in       = tgt_ff;
      mode_in      = mode_ff;
      sweep_in     = sweep_ff;
      op_in        = op_ff;
      kind_in      = kind_ff;
      level_in     = level_ff;
      value_in     = value_ff;
      cvalid_in    = cvalid_ff;
      ckind_in     = ckind_ff;
      cindex_in    = cindex_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      last_in      = last_ff;
      prev_in      = prev_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_wd       = unit_row;
      pick_hit     = 1'b0;
      pick_kind    = KIND_SLIDER;
      pick_ext     = '0;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wd = '0;
            if (addr_ff == LAST) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_payload.op;
               kind_in   = req_payload.store_kind;
               level_in  = req_payload.midi_value;
               tgt_in    = idx_addr;
               addr_in   = idx_addr;
               value_in  = 7'd0;
               cvalid_in = 1'b0;
               ckind_in  = 2'd0;
               cindex_in = 7'd0;
               found_in  = '0;
               sweep_in  = 1'b0;
               mode_in   = MODE_NONE;
               state_in  = S_DONE;
               unique case (req_payload.op)
                  OP_MIDI: begin
                     if (idx_ok) begin
                        state_in = S_RD;
                        if (req_payload.midi_status == ST_PRESS) begin
                           mode_in  = MODE_PRESS;
                           sweep_in = 1'b1;
                           addr_in  = '0;
                           if (last_ff != $signed({1'b0, req_idx})) begin
                              prev_in = last_ff;
                              last_in = $signed({1'b0, req_idx});
                              flag_in = 1'b1;
                           end
                        end else if (req_payload.midi_status == ST_RELEASE) begin
                           mode_in = MODE_RELEASE;
                        end else begin
                           mode_in = MODE_SLIDER;
                        end
                     end
                  end
                  OP_READ: begin
                     if (idx_ok) begin
                        mode_in  = MODE_READ;
                        state_in = S_RD;
                     end
                  end
                  OP_CLEAR: begin
                     mode_in  = MODE_CLEAR;
                     sweep_in = 1'b1;
                     addr_in  = '0;
                     state_in = S_RD;
                  end
                  OP_POP: begin
                     mode_in  = MODE_SCAN;
                     sweep_in = 1'b1;
                     addr_in  = '0;
                     state_in = S_RD;
                  end
                  default: ;
               endcase
            end
         end
         S_RD: begin
            state_in = S_WR;
         end
         S_WR: begin
            mem_we = (mode_ff != MODE_READ) && (mode_ff != MODE_SCAN) &&
                     (mode_ff != MODE_NONE);
            if (mode_ff == MODE_READ) begin
               unique case (kind_ff)
                  KIND_SLIDER:   value_in = rd_row_ff.slider;
                  KIND_HELD:     value_in = {6'd0, rd_row_ff.held};
                  KIND_TOGGLE:   value_in = {6'd0, rd_row_ff.toggle};
                  KIND_SELECTOR: value_in = {6'd0, rd_row_ff.selector};
                  default:       value_in = 7'd0;
               endcase
            end
            if (mode_ff == MODE_SCAN) begin
               for (int k = 0; k < 4; k++) begin
                  if (rd_row_ff.dirty[k] && !found_ff[k]) begin
                     found_in[k] = 1'b1;
                     fidx_in[k]  = addr_ff;
                  end
               end
            end
            if (sweep_ff && (addr_ff != LAST)) begin
               addr_in  = addr_ff + 1'b1;
               state_in = S_RD;
            end else if (mode_ff == MODE_SCAN) begin
               for (int k = 3; k >= 0; k--) begin
                  if (found_in[k]) begin
                     pick_hit  = 1'b1;
                     pick_kind = 2'(k);
                  end
               end
               pick_ext = {7'd0, fidx_in[pick_kind]};
               if (pick_hit) begin
                  cvalid_in = 1'b1;
                  ckind_in  = pick_kind;
                  cindex_in = pick_ext[6:0];
                  kind_in   = pick_kind;
                  addr_in   = fidx_in[pick_kind];
                  mode_in   = MODE_POP;
                  sweep_in  = 1'b0;
                  state_in  = S_RD;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_in.value_out       = value_ff;
               rsp_in.changed_valid   = cvalid_ff;
               rsp_in.changed_kind    = ckind_ff;
               rsp_in.changed_index   = cindex_ff;
               rsp_in.last_button     = last_ff;
               rsp_in.previous_button = prev_ff;
               rsp_in.button_changed  = flag_ff;
               if (op_ff == OP_TAKE_FLAG) flag_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         last_ff      <= NO_BUTTON;
         prev_ff      <= NO_BUTTON;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         last_ff      <= last_in;
         prev_ff      <= prev_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff    <= tgt_in;
      mode_ff   <= mode_in;
      sweep_ff  <= sweep_in;
      op_ff     <= op_in;
      kind_ff   <= kind_in;
      level_ff  <= level_in;
      value_ff  <= value_in;
      cvalid_ff <= cvalid_in;
      ckind_ff  <= ckind_in;
      cindex_ff <= cindex_in;
      found_ff  <= found_in;
      fidx_ff   <= fidx_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem_ff[addr_ff] <= mem_wd;
      rd_row_ff <= mem_ff[addr_ff];
   end

endmodule

FILE: sv/mcst_checker.sv
// -----------------------------------------------------------------------------
// MIDI control state tracker checker
// Port-level checks on result items, bound to the top level.
// -----------------------------------------------------------------------------
module mcst_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input mcst_pkg::req_type req_payload,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input mcst_pkg::rsp_type rsp_payload
);
   import mcst_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result item changed");

   a_pop_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.changed_valid |->
         rsp_payload.changed_kind == 2'd0 && rsp_payload.changed_index == 7'd0)
      else $error("pop fields set without a popped channel");

   a_read_vs_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.value_out != 7'd0 |-> !rsp_payload.changed_valid)
      else $error("read value and popped channel in one item");

   a_button_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_payload.last_button == NO_BUTTON &&
          rsp_payload.previous_button == NO_BUTTON) ||
         (rsp_payload.last_button != NO_BUTTON &&
          rsp_payload.last_button != rsp_payload.previous_button))
      else $error("last and previous button inconsistent");

   logic unused_req;
   assign unused_req = req_valid ^ req_stall ^ (^req_payload);

endmodule

bind midi_control_state_tracker mcst_checker u_mcst_checker (.*);

FILE: dv/tb_top.sv
// -----------------------------------------------------------------------------
// MIDI control state tracker testbench
// Drives directed and random items through the tracker, predicts every
// result from a local copy of the channel stores and dirty flags, and compares
// each result field by field, with random idling and stalls on both sides.
// -----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mcst_pkg::*;

   localparam int NCH          = 128;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int RANDOM_ITEMS = 430;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;

   int req_idle_pct = 22;
   int rsp_idle_pct = 22;
   int hold_requests = 0;
   int mismatches = 0;
   int cycle_count = 0;

   rsp_type expected_rsp_q[$];

   logic [6:0]        slider_lvl [NCH] = '{default: '0};
   bit                held_bit   [NCH];
   bit                toggle_bit [NCH];
   bit                select_bit [NCH];
   bit                dirty_map  [4*NCH];
   logic signed [7:0] last_btn = NO_BUTTON;
   logic signed [7:0] prev_btn = NO_BUTTON;
   bit                btn_flag;

   midi_control_state_tracker #(.NUM_CHANNELS(NCH)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic logic [6:0] stored_value(logic [1:0] kind, int idx);
      case (kind)
         KIND_SLIDER: return slider_lvl[idx];
         KIND_HELD:   return {6'd0, held_bit[idx]};
         KIND_TOGGLE: return {6'd0, toggle_bit[idx]};
         default:     return {6'd0, select_bit[idx]};
      endcase
   endfunction

   function automatic void write_store(logic [1:0] kind, int idx, logic [6:0] v);
      case (kind)
         KIND_SLIDER: slider_lvl[idx] = v;
         KIND_HELD:   held_bit[idx]   = v[0];
         KIND_TOGGLE: toggle_bit[idx] = v[0];
         default:     select_bit[idx] = v[0];
      endcase
   endfunction

   function automatic void update_store(logic [1:0] kind, int idx, logic [6:0] v);
      if (stored_value(kind, idx) != v) begin
         write_store(kind, idx, v);
         dirty_map[kind*NCH + idx] = 1'b1;
      end
   endfunction

   function automatic rsp_type track_item(req_type item);
      rsp_type res;
      int      idx;
      res = '0;
      idx = item.channel_index;
      case (item.op)
         OP_MIDI: begin
            if (item.midi_status == ST_PRESS) begin
               if (last_btn != idx) begin
                  prev_btn = last_btn;
                  last_btn = 8'(idx);
                  btn_flag = 1'b1;
               end
               update_store(KIND_HELD, idx, 7'd1);
               update_store(KIND_TOGGLE, idx, {6'd0, ~toggle_bit[idx]});
               for (int i = 0; i < NCH; i++)
                  if (i != idx) update_store(KIND_SELECTOR, i, 7'd0);
               update_store(KIND_SELECTOR, idx, 7'd1);
            end else if (item.midi_status == ST_RELEASE) begin
               update_store(KIND_HELD, idx, 7'd0);
            end else begin
               update_store(KIND_SLIDER, idx, item.midi_value);
            end
         end
         OP_READ: res.value_out = stored_value(item.store_kind, idx);
         OP_CLEAR: begin
            for (int i = 0; i < NCH; i++) begin
               if (stored_value(item.store_kind, i) != 7'd0)
                  dirty_map[item.store_kind*NCH + i] = 1'b1;
               write_store(item.store_kind, i, 7'd0);
            end
         end
         OP_POP: begin
            for (int i = 0; i < 4*NCH; i++) begin
               if (dirty_map[i]) begin
                  dirty_map[i]      = 1'b0;
                  res.changed_valid = 1'b1;
                  res.changed_kind  = 2'(i / NCH);
                  res.changed_index = 7'(i % NCH);
                  break;
               end
            end
         end
         default: ;
      endcase
      res.last_button     = last_btn;
      res.previous_button = prev_btn;
      res.button_changed  = btn_flag;
      if (item.op == OP_TAKE_FLAG) btn_flag = 1'b0;
      return res;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $error("result with no item outstanding: %h", rsp_payload);
            mismatches++;
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("value_out", want.value_out, rsp_payload.value_out);
            check_field("changed_valid", want.changed_valid, rsp_payload.changed_valid);
            check_field("changed_kind", want.changed_kind, rsp_payload.changed_kind);
            check_field("changed_index", want.changed_index, rsp_payload.changed_index);
            check_field("last_button", want.last_button, rsp_payload.last_button);
            check_field("previous_button", want.previous_button,
                        rsp_payload.previous_button);
            check_field("button_changed", want.button_changed, rsp_payload.button_changed);
         end
      end
   end

   initial begin
      int holds_done;
      holds_done = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests > holds_done) begin
            holds_done++;
            for (int n = 0; n < HOLD_CYCLES; n++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   function automatic req_type make_item(logic [2:0] op, logic [7:0] status,
                                         logic [6:0] idx, logic [6:0] value,
                                         logic [1:0] kind);
      req_type item;
      item.op            = op;
      item.midi_status   = status;
      item.channel_index = idx;
      item.midi_value    = value;
      item.store_kind    = kind;
      return item;
   endfunction

   function automatic req_type random_item();
      req_type item;
      int      pick;
      item      = req_type'({$urandom, $urandom});
      pick      = $urandom_range(99);
      item.op   = OP_MIDI;
      if ($urandom_range(3) != 0) item.channel_index = 7'($urandom_range(7));
      if (pick < 30) begin
         if ($urandom_range(1) == 0) item.midi_status = ST_CONTROL;
      end else if (pick < 48) begin
         item.midi_status = ST_PRESS;
      end else if (pick < 58) begin
         item.midi_status = ST_RELEASE;
      end else if (pick < 72) begin
         item.op = OP_READ;
      end else if (pick < 86) begin
         item.op = OP_POP;
      end else if (pick < 90) begin
         item.op = OP_CLEAR;
      end else if (pick < 95) begin
         item.op = OP_TAKE_FLAG;
      end else begin
         item.op = 3'($urandom_range(7));
      end
      return item;
   endfunction

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      expected_rsp_q.insert(expected_rsp_q.size(), track_item(item));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp_q.size() != 0);
   endtask

   task automatic test_reset_state();
      send_item(make_item(OP_READ, 8'd0, 7'd0, 7'd0, KIND_SLIDER));
      send_item(make_item(OP_READ, 8'd0, 7'd127, 7'd0, KIND_SELECTOR));
      send_item(make_item(OP_POP, 8'd0, 7'd0, 7'd0, KIND_SLIDER));
      send_item(make_item(OP_TAKE_FLAG, 8'd0, 7'd0, 7'd0, KIND_SLIDER));
   endtask

   task automatic test_control_messages();
      send_item(make_item(OP_MIDI, ST_CONTROL, 7'd0, 7'd127, KIND_SLIDER));
      send_item(make_item(OP_MIDI, 8'd255, 7'd127, 7'd127, KIND_HELD));
      send_item(make_item(OP_MIDI, 8'd0, 7'd127, 7'd127, KIND_TOGGLE));
      send_item(make_item(OP_MIDI, ST_CONTROL, 7'd3, 7'd0, KIND_SELECTOR));
      send_item(make_item(OP_READ, 8'd0, 7'd0, 7'd0, KIND_SLIDER));
      send_item(make_item(OP_READ, 8'd255, 7'd127, 7'd127, KIND_SLIDER));
   endtask

   task automatic test_button_presses();
      send_item(make_item(OP_MIDI, ST_PRESS, 7'd5, 7'd0, KIND_SLIDER));
      send_item(make_item(OP_MIDI, ST_PRESS, 7'd5, 7'd64, KIND_SLIDER));
      send_item(make_item(OP_MIDI, ST_PRESS, 7'd127, 7'd127, KIND_SLIDER));
      send_item(make_item(OP_MIDI, ST_RELEASE, 7'd5, 7'd0, KIND_SLIDER));
      send_item(make_item(OP_READ, 8'd0, 7'd5, 7'd0, KIND_HELD));
      send_item(make_item(OP_READ, 8'd0, 7'd5, 7'd0, KIND_TOGGLE));
      send_item(make_item(OP_READ, 8'd0, 7'd127, 7'd0, KIND_SELECTOR));
      send_item(make_item(OP_TAKE_FLAG, 8'd0, 7'd0, 7'd0, KIND_SLIDER));
      send_item(make_item(OP_TAKE_FLAG, 8'd0, 7'd0, 7'd0, KIND_SLIDER));
   endtask

   task automatic test_clear_and_pop();
      send_item(make_item(OP_CLEAR, 8'd0, 7'd0, 7'd0, KIND_TOGGLE));
      send_item(make_item(OP_POP, 8'd0, 7'd0, 7'd0, KIND_SLIDER));
      send_item(make_item(OP_POP, 8'd0, 7'd0, 7'd0, KIND_SLIDER));
      send_item(make_item(OP_UNUSED, 8'd255, 7'd127, 7'd127, KIND_SELECTOR));
   endtask

   task automatic test_output_backpressure();
      req_type item;
      hold_requests++;
      for (int n = 0; n < 12; n++) begin
         item    = random_item();
         item.op = OP_READ;
         send_item(item);
      end
   endtask

   task automatic test_random_traffic(input int count);
      for (int n = 0; n < count; n++) begin
         if (n == count / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end else if (n == count / 3 + 60) begin
            req_idle_pct = 22;
            rsp_idle_pct = 22;
         end
         if (n == count / 2) wait_drained();
         send_item(random_item());
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_control_messages();
      test_button_presses();
      test_clear_and_pop();
      wait_drained();
      test_output_backpressure();
      test_random_traffic(RANDOM_ITEMS);
      wait_drained();
      repeat (2*NCH + 8) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
